// ===== hdl/bdeq_pkg.sv =====
// Shared types and constants for the bounded deque.
// Holds the depth, opcode and status codes, and the command that drives the cell row.
// No dependencies.
package bdeq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic signed [31:0] data_t;
    typedef logic [2:0]         opcode_t;
    typedef logic [1:0]         status_t;
    typedef logic [CNT_W-1:0]   count_t;

    localparam opcode_t OP_PUSH_FRONT = 3'd0;
    localparam opcode_t OP_PUSH_BACK  = 3'd1;
    localparam opcode_t OP_POP_FRONT  = 3'd2;
    localparam opcode_t OP_POP_BACK   = 3'd3;
    localparam opcode_t OP_LIST       = 3'd4;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_OVERFLOW  = 2'd1;
    localparam status_t STAT_UNDERFLOW = 2'd2;
    localparam status_t STAT_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_POP_BACK,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        data_t    push_value;
    } cell_cmd_t;

endpackage

// ===== hdl/bdeq_cell.sv =====
// One cell of the deque row: holds one entry and its occupied flag.
// Trades entries with its neighbors on each shift or rotate command.
// Depends on bdeq_pkg.
module bdeq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  bdeq_pkg::cell_cmd_t cmd,
    input  bdeq_pkg::data_t     left_value,
    input  logic                left_occ,
    input  bdeq_pkg::data_t     right_value,
    input  logic                right_occ,
    input  bdeq_pkg::data_t     head_value,
    output bdeq_pkg::data_t     value,
    output logic                occ
);
    import bdeq_pkg::*;

    data_t value_reg;
    data_t value_next;
    logic  occ_reg;
    logic  occ_next;

    always_comb begin
        value_next = value_reg;
        occ_next   = occ_reg;
        case (cmd.op)
            CELL_PUSH_FRONT: begin
                value_next = left_value;
                occ_next   = left_occ;
            end
            CELL_PUSH_BACK: begin
                if (!occ_reg && left_occ) begin
                    value_next = cmd.push_value;
                    occ_next   = 1'b1;
                end
            end
            CELL_POP_FRONT: begin
                value_next = right_value;
                occ_next   = right_occ;
            end
            CELL_POP_BACK: begin
                if (occ_reg && !right_occ) begin
                    occ_next = 1'b0;
                end
            end
            CELL_ROTATE: begin
                // tail cell wraps the head entry around
                if (occ_reg) begin
                    value_next = right_occ ? right_value : head_value;
                end
            end
            default: begin
                value_next = value_reg;
                occ_next   = occ_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign value = value_reg;
    assign occ   = occ_reg;

endmodule

// ===== hdl/bounded_double_ended_queue_top.sv =====
// Bounded deque top level: request decode, output register and the row of cells.
// A push or pop result is valid in the cycle after its beat is accepted; one push or pop per cycle
// while the output is free. A list request holds off input until its last entry is emitted and emits
// one entry per cycle through the output register once in the list state; output stalls stretch it.
// Synchronous active-low reset empties the queue; entry values are undefined until pushed.
module bounded_double_ended_queue_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bdeq_pkg::opcode_t   s_opcode,
    input  bdeq_pkg::data_t     s_push_value,
    output logic                m_valid,
    input  logic                m_ready,
    output bdeq_pkg::data_t     m_item_value,
    output bdeq_pkg::status_t   m_status,
    output logic                m_last
);
    import bdeq_pkg::*;

    typedef enum logic {S_IDLE, S_LIST} state_t;

    state_t    state_reg, state_next;
    count_t    count_reg, count_next;
    count_t    rem_reg, rem_next;
    logic      m_valid_reg, m_valid_next;
    data_t     m_item_value_reg, m_item_value_next;
    status_t   m_status_reg, m_status_next;
    logic      m_last_reg, m_last_next;

    cell_cmd_t        cmd;
    data_t            cell_value [DEPTH];
    logic [DEPTH-1:0] cell_occ;
    data_t            tail_value;
    logic             out_free;
    logic             accept;
    logic             full;
    logic             empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            data_t left_value;
            logic  left_occ;
            data_t right_value;
            logic  right_occ;
            if (gi == 0) begin : g_head
                assign left_value = cmd.push_value;
                assign left_occ   = 1'b1;
            end else begin : g_mid_left
                assign left_value = cell_value[gi-1];
                assign left_occ   = cell_occ[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign right_value = '0;
                assign right_occ   = 1'b0;
            end else begin : g_mid_right
                assign right_value = cell_value[gi+1];
                assign right_occ   = cell_occ[gi+1];
            end
            bdeq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .left_value  (left_value),
                .left_occ    (left_occ),
                .right_value (right_value),
                .right_occ   (right_occ),
                .head_value  (cell_value[0]),
                .value       (cell_value[gi]),
                .occ         (cell_occ[gi])
            );
        end
    endgenerate

    always_comb begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_occ[i] && (i == DEPTH - 1 || !cell_occ[(i + 1) % DEPTH])) begin
                tail_value = tail_value | cell_value[i];
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        rem_next          = rem_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_item_value_next = m_item_value_reg;
        m_status_next     = m_status_reg;
        m_last_next       = m_last_reg;
        cmd.op            = CELL_HOLD;
        cmd.push_value    = s_push_value;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            m_valid_next      = 1'b1;
                            m_item_value_next = '0;
                            m_last_next       = 1'b1;
                            if (full) begin
                                m_status_next = STAT_OVERFLOW;
                            end else begin
                                m_status_next = STAT_OK;
                                count_next    = count_reg + CNT_W'(1);
                                cmd.op        = (s_opcode == OP_PUSH_FRONT) ?
                                                CELL_PUSH_FRONT : CELL_PUSH_BACK;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (empty) begin
                                m_item_value_next = '0;
                                m_status_next     = STAT_UNDERFLOW;
                            end else begin
                                m_status_next = STAT_OK;
                                count_next    = count_reg - CNT_W'(1);
                                if (s_opcode == OP_POP_FRONT) begin
                                    m_item_value_next = cell_value[0];
                                    cmd.op            = CELL_POP_FRONT;
                                end else begin
                                    m_item_value_next = tail_value;
                                    cmd.op            = CELL_POP_BACK;
                                end
                            end
                        end
                        OP_LIST: begin
                            if (empty) begin
                                m_valid_next      = 1'b1;
                                m_item_value_next = '0;
                                m_status_next     = STAT_EMPTY;
                                m_last_next       = 1'b1;
                            end else begin
                                state_next = S_LIST;
                                rem_next   = count_reg;
                            end
                        end
                        default: begin
                            // drop undefined requests
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_item_value_next = cell_value[0];
                    m_status_next     = STAT_OK;
                    m_last_next       = (rem_reg == CNT_W'(1));
                    cmd.op            = CELL_ROTATE;
                    rem_next          = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_item_value_reg <= m_item_value_next;
        m_status_reg     <= m_status_next;
        m_last_reg       <= m_last_next;
        rem_reg          <= rem_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_item_value = m_item_value_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_occ_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_occ) == int'(count_reg))
        else $error("cell occupancy disagrees with entry count");

    a_no_input_while_listing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> !s_ready)
        else $error("input taken during list");

    a_pop_empty_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && empty && (s_opcode == OP_POP_FRONT || s_opcode == OP_POP_BACK))
        |=> (m_valid && m_status == STAT_UNDERFLOW && m_last))
        else $error("pop on empty queue did not report underflow");
`endif

endmodule

// ===== tb/bdeq_checker.sv =====
// Checker for the bounded deque: watches the request and result channels,
// predicts the results of each accepted request and compares them in order.
// Depends on bdeq_pkg for the depth, field types and the opcode and status codes.
`timescale 1ns / 100ps

module bdeq_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  bdeq_pkg::opcode_t s_opcode,
    input  bdeq_pkg::data_t   s_push_value,
    input  logic              m_valid,
    input  logic              m_ready,
    input  bdeq_pkg::data_t   m_item_value,
    input  bdeq_pkg::status_t m_status,
    input  logic              m_last,
    output int                mismatch_count,
    output int                pending_results,
    output int                results_checked,
    output int                overflow_hits,
    output int                underflow_hits,
    output int                full_lists
);
    import bdeq_pkg::*;

    typedef struct {
        data_t   value;
        status_t status;
        logic    last;
    } deq_result_t;

    deq_result_t queued_results[$];
    deq_result_t head_result;
    data_t       ring[DEPTH];
    int          front_pos;
    int          fill;
    int          error_total;
    int          checked_total;
    int          overflow_total;
    int          underflow_total;
    int          full_list_total;

    task automatic report_mismatch(input string msg);
        error_total++;
        if (error_total <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    function automatic void add_result(data_t value, status_t status, logic last);
        deq_result_t r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        queued_results.push_back(r);
    endfunction

    function automatic void predict_request(opcode_t op, data_t value);
        int slot;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    overflow_total++;
                    add_result('0, STAT_OVERFLOW, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        front_pos = (front_pos + DEPTH - 1) % DEPTH;
                        slot = front_pos;
                    end else begin
                        slot = (front_pos + fill) % DEPTH;
                    end
                    ring[slot] = value;
                    fill++;
                    add_result('0, STAT_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (fill == 0) begin
                    underflow_total++;
                    add_result('0, STAT_UNDERFLOW, 1'b1);
                end else if (op == OP_POP_FRONT) begin
                    add_result(ring[front_pos], STAT_OK, 1'b1);
                    front_pos = (front_pos + 1) % DEPTH;
                    fill--;
                end else begin
                    add_result(ring[(front_pos + fill - 1) % DEPTH], STAT_OK, 1'b1);
                    fill--;
                end
            end
            OP_LIST: begin
                if (fill == 0) begin
                    add_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    if (fill == DEPTH) full_list_total++;
                    for (int i = 0; i < fill; i++) begin
                        add_result(ring[(front_pos + i) % DEPTH], STAT_OK, i == fill - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            queued_results.delete();
            front_pos       = 0;
            fill            = 0;
            error_total     = 0;
            checked_total   = 0;
            overflow_total  = 0;
            underflow_total = 0;
            full_list_total = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (queued_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d status %0d last %0b",
                                              m_item_value, m_status, m_last));
                end else begin
                    head_result = queued_results.pop_front();
                    checked_total++;
                    if (m_item_value !== head_result.value || m_status !== head_result.status
                            || m_last !== head_result.last) begin
                        report_mismatch($sformatf(
                            "expected value %0d status %0d last %0b, got %0d %0d %0b",
                            head_result.value, head_result.status, head_result.last,
                            m_item_value, m_status, m_last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_request(s_opcode, s_push_value);
            end
        end
        mismatch_count  <= error_total;
        pending_results <= queued_results.size();
        results_checked <= checked_total;
        overflow_hits   <= overflow_total;
        underflow_hits  <= underflow_total;
        full_lists      <= full_list_total;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the bounded deque: clock, reset, request stimulus, result back-pressure
// and the verdict. Depends on bdeq_pkg, bounded_double_ended_queue_top and bdeq_checker.
`timescale 1ns / 100ps

module tb_top;
    import bdeq_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TARGET_ITEMS = 360;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE       = 20;

    logic    aclk         = 1'b0;
    logic    aresetn      = 1'b0;
    logic    s_valid      = 1'b0;
    logic    s_ready;
    opcode_t s_opcode     = OP_PUSH_FRONT;
    data_t   s_push_value = '0;
    logic    m_valid;
    logic    m_ready      = 1'b0;
    data_t   m_item_value;
    status_t m_status;
    logic    m_last;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int overflow_hits;
    int underflow_hits;
    int full_lists;

    int cycle_count     = 0;
    int requests_sent   = 0;
    int fill_estimate   = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit pressure_done   = 1'b0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int stall_left      = 0;

    bounded_double_ended_queue_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item_value (m_item_value),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    bdeq_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_value    (m_item_value),
        .m_status        (m_status),
        .m_last          (m_last),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .overflow_hits   (overflow_hits),
        .underflow_hits  (underflow_hits),
        .full_lists      (full_lists)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: a long hold when asked, else random stalls or steady acceptance.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (receiver_steady) begin
            m_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:  begin
                    m_ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                4:           begin
                    m_ready <= 1'b0;
                    stall_left = $urandom_range(6, 30);
                end
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic data_t random_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            4:       return data_t'($urandom_range(0, 15));
            default: return data_t'($urandom);
        endcase
    endfunction

    function automatic opcode_t random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return opcode_t'($urandom_range(5, 7));
        if (r < 26) return OP_PUSH_FRONT;
        if (r < 48) return OP_PUSH_BACK;
        if (r < 68) return OP_POP_FRONT;
        if (r < 88) return OP_POP_BACK;
        return OP_LIST;
    endfunction

    // Offer one beat and hold it until accepted; leave valid high for the caller unless a random gap follows.
    task automatic issue(input opcode_t op, input data_t value);
        int n;
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_push_value <= value;
        do @(posedge aclk); while (!s_ready);
        if (op <= OP_LIST) requests_sent++;
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && fill_estimate < DEPTH) begin
            fill_estimate++;
        end else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && fill_estimate > 0) begin
            fill_estimate--;
        end
        n = sender_steady ? 0 : pick_gap();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    function automatic opcode_t either_push();
        return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    endfunction

    function automatic opcode_t either_pop();
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty ring, extremes at both ends, front index wrap, unused opcodes.
        issue(OP_POP_FRONT, random_value());
        issue(OP_POP_BACK, random_value());
        issue(OP_LIST, random_value());
        issue(OP_PUSH_FRONT, 32'h8000_0000);
        issue(OP_PUSH_BACK, 32'h7fff_ffff);
        issue(OP_PUSH_FRONT, '0);
        issue(OP_PUSH_BACK, '1);
        issue(opcode_t'(5), random_value());
        issue(opcode_t'(6), random_value());
        issue(opcode_t'(7), random_value());
        issue(OP_LIST, random_value());
        issue(OP_POP_FRONT, random_value());
        issue(OP_POP_BACK, random_value());
        issue(OP_POP_BACK, random_value());
        issue(OP_POP_FRONT, random_value());
        issue(OP_POP_BACK, random_value());
        issue(OP_LIST, random_value());
        issue(OP_PUSH_BACK, 32'h5555_5555);
        issue(OP_PUSH_FRONT, 32'haaaa_aaaa);
        issue(OP_LIST, random_value());
        issue(OP_POP_BACK, random_value());
        issue(OP_POP_BACK, random_value());
        wait_drained();

        while (requests_sent < TARGET_ITEMS) begin
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            if (!pressure_done && requests_sent >= TARGET_ITEMS / 2) begin
                // Stall the result side while requests keep coming back to back.
                wait_drained();
                hold_requests++;
                sender_steady = 1'b1;
                repeat (40) issue(random_op(), random_value());
                pressure_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    4, 5: begin
                        while (fill_estimate < DEPTH) issue(either_push(), random_value());
                        repeat ($urandom_range(1, 2)) issue(either_push(), random_value());
                        issue(OP_LIST, random_value());
                    end
                    6, 7: begin
                        while (fill_estimate > 0) issue(either_pop(), random_value());
                        issue(either_pop(), random_value());
                        issue(OP_LIST, random_value());
                    end
                    8: begin
                        issue(OP_LIST, random_value());
                        repeat ($urandom_range(1, 4)) issue(either_push(), random_value());
                        issue(either_pop(), random_value());
                        issue(OP_LIST, random_value());
                    end
                    9: wait_drained();
                    default: begin
                        repeat ($urandom_range(4, 20)) issue(random_op(), random_value());
                    end
                endcase
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d requests, checked %0d results: %0d overflows, %0d underflows,",
                 requests_sent, results_checked, overflow_hits, underflow_hits);
        $display("%0d lists of a full ring, one long result-side hold with input stalled.",
                 full_lists);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
